// File: rtl/ssgs_pkg.sv
`timescale 1ns / 1ps
package ssgs_pkg;

   localparam int MAX_WIDTH  = 32;
   localparam int MAX_HEIGHT = 32;
   localparam int VALUE_BITS = 32;

   localparam int COL_BITS  = $clog2(MAX_WIDTH);
   localparam int ROW_BITS  = $clog2(MAX_HEIGHT);
   localparam int ADDR_BITS = COL_BITS + ROW_BITS;
   localparam int CELLS     = MAX_WIDTH * MAX_HEIGHT;
   localparam int GRID_BITS = 6;

   localparam int DATA_BITS     = 32;
   localparam int SAT_BITS      = (VALUE_BITS > 32) ? 32 : VALUE_BITS;
   localparam int OPND_BITS     = 33;
   localparam int PROD_BITS     = 2 * OPND_BITS;
   localparam int ACC_BITS      = 52;
   localparam int DIFF_BITS     = 53;
   localparam int KEEP_BITS     = 34;
   localparam int DIVIDEND_BITS = 50;
   localparam int DIVISOR_BITS  = 32;
   localparam int QUO_BITS      = DIVIDEND_BITS + 1;
   localparam int STEP_BITS     = $clog2(DIVIDEND_BITS + 1);
   localparam int RESID_BITS    = 64;
   localparam int TOL_BITS      = 31;
   localparam int TOL2_BITS     = 2 * TOL_BITS;

   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS  = 31;

   localparam logic [1:0] OP_WRITE = 2'd0;
   localparam logic [1:0] OP_SOLVE = 2'd1;
   localparam logic [1:0] OP_READ  = 2'd2;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_MAX_ITER  = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_CHK_IVL   = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_TOLERANCE = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_RELAX     = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_RB_MODE   = 3'd4;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_GRID_W    = 3'd5;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_GRID_H    = 3'd6;

   // neighbor fetch phases of one cell
   localparam logic [2:0] PH_SELF  = 3'd0;
   localparam logic [2:0] PH_RIGHT = 3'd1;
   localparam logic [2:0] PH_LEFT  = 3'd2;
   localparam logic [2:0] PH_UP    = 3'd3;
   localparam logic [2:0] PH_DOWN  = 3'd4;
   localparam logic [2:0] PH_END   = 3'd5;

   localparam logic signed [OPND_BITS-1:0] ONE_Q14 = 33'sd16384;

   localparam logic signed [ACC_BITS-1:0] VAL_MAX =
      ACC_BITS'((64'sd1 <<< (SAT_BITS - 1)) - 64'sd1);
   localparam logic signed [ACC_BITS-1:0] VAL_MIN =
      ACC_BITS'(-(64'sd1 <<< (SAT_BITS - 1)));

   typedef enum logic [19:0] {
      S_IDLE   = 20'b1 << 0,
      S_RDOUT  = 20'b1 << 1,
      S_TOL    = 20'b1 << 2,
      S_BEGIN  = 20'b1 << 3,
      S_CELL   = 20'b1 << 4,
      S_ADDR   = 20'b1 << 5,
      S_DATA   = 20'b1 << 6,
      S_ACC    = 20'b1 << 7,
      S_POST   = 20'b1 << 8,
      S_WD     = 20'b1 << 9,
      S_KEEP   = 20'b1 << 10,
      S_DIVW   = 20'b1 << 11,
      S_WRITE  = 20'b1 << 12,
      S_RPOST  = 20'b1 << 13,
      S_RSQ    = 20'b1 << 14,
      S_NEXT   = 20'b1 << 15,
      S_SWEND  = 20'b1 << 16,
      S_RDONE  = 20'b1 << 17,
      S_ITNEXT = 20'b1 << 18,
      S_OUT    = 20'b1 << 19
   } state_type;

   function automatic logic signed [DATA_BITS-1:0] sat_value(
      input logic signed [ACC_BITS-1:0] v);
      logic signed [ACC_BITS-1:0] r;
      if (v > VAL_MAX) r = VAL_MAX;
      else if (v < VAL_MIN) r = VAL_MIN;
      else r = v;
      return r[DATA_BITS-1:0];
   endfunction

   function automatic logic [RESID_BITS-1:0] sat_add(
      input logic [RESID_BITS-1:0] a,
      input logic [RESID_BITS-1:0] b);
      logic [RESID_BITS:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[RESID_BITS] ? {RESID_BITS{1'b1}} : s[RESID_BITS-1:0];
   endfunction

endpackage

// File: rtl/ssgs_if.sv
`timescale 1ns / 1ps
interface ssgs_req_if;
   logic                                       valid;
   logic                                       ready;
   logic [1:0]                                 opcode;
   logic [ssgs_pkg::COL_BITS-1:0]              col;
   logic [ssgs_pkg::ROW_BITS-1:0]              row;
   logic signed [ssgs_pkg::DATA_BITS-1:0]      center_coeff;
   logic signed [ssgs_pkg::DATA_BITS-1:0]      right_coeff;
   logic signed [ssgs_pkg::DATA_BITS-1:0]      up_coeff;
   logic signed [ssgs_pkg::DATA_BITS-1:0]      rhs_value;
   logic signed [ssgs_pkg::DATA_BITS-1:0]      initial_guess;

   modport source (output valid, opcode, col, row, center_coeff, right_coeff, up_coeff,
                   rhs_value, initial_guess, input ready);
   modport sink (input valid, opcode, col, row, center_coeff, right_coeff, up_coeff,
                 rhs_value, initial_guess, output ready);
endinterface

interface ssgs_rsp_if;
   logic                                  valid;
   logic                                  ready;
   logic signed [ssgs_pkg::DATA_BITS-1:0] cell_value;
   logic                                  converged;
   logic [15:0]                           iterations_used;
   logic [ssgs_pkg::RESID_BITS-1:0]       residual_sq;

   modport source (output valid, cell_value, converged, iterations_used, residual_sq,
                   input ready);
   modport sink (input valid, cell_value, converged, iterations_used, residual_sq,
                 output ready);
endinterface

// File: rtl/ssgs_ram.sv
`timescale 1ns / 1ps
module ssgs_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) mem_ff[waddr] <= wdata;
      if (re) rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// File: rtl/ssgs_mul.sv
`timescale 1ns / 1ps
module ssgs_mul (
   input  logic                                   clock,
   input  logic signed [ssgs_pkg::OPND_BITS-1:0]  a,
   input  logic signed [ssgs_pkg::OPND_BITS-1:0]  b,
   output logic signed [ssgs_pkg::PROD_BITS-1:0]  product
);

   logic signed [ssgs_pkg::PROD_BITS-1:0] prod_ff;
   logic signed [ssgs_pkg::PROD_BITS-1:0] prod_in;

   assign prod_in = a * b;

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   assign product = prod_ff;

endmodule

// File: rtl/ssgs_div.sv
`timescale 1ns / 1ps
module ssgs_div (
   input  logic                                       clock,
   input  logic                                       reset,
   input  logic                                       start,
   input  logic signed [ssgs_pkg::DIVIDEND_BITS-1:0]  dividend,
   input  logic signed [ssgs_pkg::DIVISOR_BITS-1:0]   divisor,
   output logic                                       busy,
   output logic signed [ssgs_pkg::QUO_BITS-1:0]       quotient
);

   localparam int NB = ssgs_pkg::DIVIDEND_BITS;
   localparam int DB = ssgs_pkg::DIVISOR_BITS;

   logic                                busy_ff, busy_in;
   logic [ssgs_pkg::STEP_BITS-1:0]      cnt_ff, cnt_in;
   logic [NB-1:0]                       quo_ff, quo_in;
   logic [DB-1:0]                       rem_ff, rem_in;
   logic [DB-1:0]                       den_ff, den_in;
   logic                                neg_ff, neg_in;
   logic [DB:0]                         trial;
   logic [DB:0]                         diff;

   assign trial = {rem_ff, quo_ff[NB-1]};
   assign diff  = trial - {1'b0, den_ff};

   always_comb begin
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      neg_in  = neg_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = ssgs_pkg::STEP_BITS'(NB);
         quo_in  = dividend[NB-1] ? (~dividend + NB'(1)) : dividend;
         den_in  = divisor[DB-1] ? (~divisor + DB'(1)) : divisor;
         rem_in  = '0;
         neg_in  = dividend[NB-1] ^ divisor[DB-1];
      end else if (busy_ff) begin
         // restoring step, one quotient bit per cycle
         if (!diff[DB]) begin
            rem_in = diff[DB-1:0];
            quo_in = {quo_ff[NB-2:0], 1'b1};
         end else begin
            rem_in = trial[DB-1:0];
            quo_in = {quo_ff[NB-2:0], 1'b0};
         end
         cnt_in = cnt_ff - ssgs_pkg::STEP_BITS'(1);
         if (cnt_ff == ssgs_pkg::STEP_BITS'(1)) busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
      cnt_ff <= cnt_in;
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
      neg_ff <= neg_in;
   end

   assign busy     = busy_ff;
   assign quotient = neg_ff ? -$signed({1'b0, quo_ff}) : $signed({1'b0, quo_ff});

endmodule

// File: rtl/stencil_sor_gauss_seidel_solver.sv
`timescale 1ns / 1ps
// Channel   Dir  Handshake     Payload
// req_chan  in   valid/ready   opcode, col, row, coefficients, rhs_value, initial_guess
// rsp_chan  out  valid/ready   cell_value, converged, iterations_used, residual_sq
// csr_*     in   write enable  csr_index, csr_write_data
//
// Writes are stored when accepted; reads pass the RAM and wait for the output register.
// A solve walks the cells one at a time through one shared multiplier and one radix-2
// divider; a relaxed cell waits for the divider, which sets the pace; a residual pass
// uses only the multiplier. req_chan.ready is low during a read or solve.
// Reset is synchronous; it loads register defaults and resets status; stores start unknown.
module stencil_sor_gauss_seidel_solver (
   input  logic                                   clock,
   input  logic                                   reset,
   ssgs_req_if.sink                               req_chan,
   ssgs_rsp_if.source                             rsp_chan,
   input  logic                                   csr_write_enable,
   input  logic [ssgs_pkg::CSR_INDEX_BITS-1:0]    csr_index,
   input  logic [ssgs_pkg::CSR_DATA_BITS-1:0]     csr_write_data
);

   localparam int CB = ssgs_pkg::COL_BITS;
   localparam int RB = ssgs_pkg::ROW_BITS;
   localparam int AB = ssgs_pkg::ADDR_BITS;
   localparam int GB = ssgs_pkg::GRID_BITS;
   localparam int DW = ssgs_pkg::DATA_BITS;

   ssgs_pkg::state_type state_ff, state_in;

   // configuration
   logic [15:0]                        max_iter_ff, max_iter_in;
   logic [15:0]                        chk_ivl_ff, chk_ivl_in;
   logic [ssgs_pkg::TOL_BITS-1:0]      tol_ff, tol_in;
   logic [15:0]                        relax_ff, relax_in;
   logic                               rb_mode_ff, rb_mode_in;
   logic [GB-1:0]                      grid_w_ff, grid_w_in;
   logic [GB-1:0]                      grid_h_ff, grid_h_in;

   // solve status
   logic [15:0]                        last_iter_ff, last_iter_in;
   logic [ssgs_pkg::RESID_BITS-1:0]    last_resid_ff, last_resid_in;
   logic                               last_conv_ff, last_conv_in;

   // sequencer
   logic [CB-1:0]                      i_ff, i_in;
   logic [RB-1:0]                      j_ff, j_in;
   logic                               p_ff, p_in;
   logic [2:0]                         ph_ff, ph_in;
   logic [15:0]                        it_ff, it_in;
   logic [15:0]                        ivl_ph_ff, ivl_ph_in;
   logic [15:0]                        ivl_ff, ivl_in;
   logic                               resid_ff, resid_in;
   logic                               final_ff, final_in;
   logic [GB-1:0]                      gw_ff, gw_in;
   logic [GB-1:0]                      gh_ff, gh_in;
   logic [ssgs_pkg::TOL2_BITS-1:0]     tol2_ff, tol2_in;
   logic signed [DW-1:0]               c_ff, c_in;
   logic signed [DW-1:0]               rt_ff, rt_in;
   logic signed [DW-1:0]               up_ff, up_in;
   logic signed [DW-1:0]               b_ff, b_in;
   logic signed [DW-1:0]               x_ff, x_in;
   logic signed [ssgs_pkg::ACC_BITS-1:0]  acc_ff, acc_in;
   logic signed [ssgs_pkg::KEEP_BITS-1:0] keep_ff, keep_in;
   logic [ssgs_pkg::RESID_BITS-1:0]    sum_ff, sum_in;

   // output register
   logic                               rsp_valid_ff, rsp_valid_in;
   logic signed [DW-1:0]               rsp_cell_ff, rsp_cell_in;
   logic                               rsp_conv_ff, rsp_conv_in;
   logic [15:0]                        rsp_iter_ff, rsp_iter_in;
   logic [ssgs_pkg::RESID_BITS-1:0]    rsp_resid_ff, rsp_resid_in;

   // datapath
   logic                               req_fire;
   logic                               rsp_free;
   logic                               rsp_load;
   logic signed [DW-1:0]               rsp_cell_load;
   logic signed [ssgs_pkg::OPND_BITS-1:0] mul_a, mul_b;
   logic signed [ssgs_pkg::PROD_BITS-1:0] prod;
   logic                               div_start;
   logic                               div_busy;
   logic signed [ssgs_pkg::DIVIDEND_BITS-1:0] div_dividend;
   logic signed [ssgs_pkg::QUO_BITS-1:0]   quotient;
   logic                               ram_re;
   logic [AB-1:0]                      raddr;
   logic [AB-1:0]                      waddr;
   logic [AB-1:0]                      host_addr;
   logic [AB-1:0]                      cell_addr;
   logic [AB-1:0]                      ph_addr;
   logic                               coef_we;
   logic                               sol_we;
   logic signed [DW-1:0]               sol_wdata;
   logic [DW-1:0]                      center_rd, right_rd, up_rd, rhs_rd, sol_rd;
   logic                               ex_right, ex_up, ex_cur;
   logic signed [ssgs_pkg::DIFF_BITS-1:0] diff;
   logic [ssgs_pkg::DIFF_BITS-1:0]     mag;
   logic signed [DW-1:0]               d_val;
   logic                               below;

   assign req_fire  = req_chan.valid && req_chan.ready;
   assign rsp_free  = !rsp_valid_ff || rsp_chan.ready;
   assign host_addr = {req_chan.row, req_chan.col};
   assign cell_addr = {j_ff, i_ff};
   assign ex_right  = (GB'(i_ff) + GB'(1)) < gw_ff;
   assign ex_up     = (GB'(j_ff) + GB'(1)) < gh_ff;
   assign below     = sum_ff < {{(ssgs_pkg::RESID_BITS - ssgs_pkg::TOL2_BITS){1'b0}}, tol2_ff};

   assign diff = ssgs_pkg::DIFF_BITS'(b_ff) - ssgs_pkg::DIFF_BITS'(acc_ff);
   assign mag  = diff[ssgs_pkg::DIFF_BITS-1] ? (~diff + ssgs_pkg::DIFF_BITS'(1)) : diff;

   always_comb begin
      if (diff > ssgs_pkg::DIFF_BITS'(32'sh7FFFFFFF)) d_val = 32'sh7FFFFFFF;
      else if (diff < -ssgs_pkg::DIFF_BITS'(32'sh7FFFFFFF) - 1) d_val = 32'sh80000000;
      else d_val = diff[DW-1:0];
   end

   always_comb begin
      unique case (ph_ff)
         ssgs_pkg::PH_SELF:  begin ex_cur = 1'b1;        ph_addr = cell_addr; end
         ssgs_pkg::PH_RIGHT: begin ex_cur = ex_right;    ph_addr = {j_ff, i_ff + CB'(1)}; end
         ssgs_pkg::PH_LEFT:  begin ex_cur = i_ff != '0;  ph_addr = {j_ff, i_ff - CB'(1)}; end
         ssgs_pkg::PH_UP:    begin ex_cur = ex_up;       ph_addr = {j_ff + RB'(1), i_ff}; end
         ssgs_pkg::PH_DOWN:  begin ex_cur = j_ff != '0;  ph_addr = {j_ff - RB'(1), i_ff}; end
         default:            begin ex_cur = 1'b0;        ph_addr = cell_addr; end
      endcase
   end

   // configuration writes
   always_comb begin
      max_iter_in = max_iter_ff;
      chk_ivl_in  = chk_ivl_ff;
      tol_in      = tol_ff;
      relax_in    = relax_ff;
      rb_mode_in  = rb_mode_ff;
      grid_w_in   = grid_w_ff;
      grid_h_in   = grid_h_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            ssgs_pkg::CSR_MAX_ITER:  max_iter_in = csr_write_data[15:0];
            ssgs_pkg::CSR_CHK_IVL:   chk_ivl_in  = csr_write_data[15:0];
            ssgs_pkg::CSR_TOLERANCE: tol_in      = csr_write_data;
            ssgs_pkg::CSR_RELAX:     relax_in    = csr_write_data[15:0];
            ssgs_pkg::CSR_RB_MODE:   rb_mode_in  = csr_write_data[0];
            ssgs_pkg::CSR_GRID_W:    grid_w_in   = csr_write_data[GB-1:0];
            ssgs_pkg::CSR_GRID_H:    grid_h_in   = csr_write_data[GB-1:0];
            default: ;
         endcase
      end
   end

   // sequencer
   always_comb begin
      state_in      = state_ff;
      last_iter_in  = last_iter_ff;
      last_resid_in = last_resid_ff;
      last_conv_in  = last_conv_ff;
      i_in          = i_ff;
      j_in          = j_ff;
      p_in          = p_ff;
      ph_in         = ph_ff;
      it_in         = it_ff;
      ivl_ph_in     = ivl_ph_ff;
      ivl_in        = ivl_ff;
      resid_in      = resid_ff;
      final_in      = final_ff;
      gw_in         = gw_ff;
      gh_in         = gh_ff;
      tol2_in       = tol2_ff;
      c_in          = c_ff;
      rt_in         = rt_ff;
      up_in         = up_ff;
      b_in          = b_ff;
      x_in          = x_ff;
      acc_in        = acc_ff;
      keep_in       = keep_ff;
      sum_in        = sum_ff;
      mul_a         = '0;
      mul_b         = '0;
      div_start     = 1'b0;
      div_dividend  = {prod[ssgs_pkg::DIVIDEND_BITS-3:0], 2'b00};
      ram_re        = 1'b0;
      raddr         = host_addr;
      waddr         = host_addr;
      coef_we       = 1'b0;
      sol_we        = 1'b0;
      sol_wdata     = ssgs_pkg::sat_value(ssgs_pkg::ACC_BITS'(req_chan.initial_guess));
      rsp_load      = 1'b0;
      rsp_cell_load = '0;

      unique case (state_ff)
         ssgs_pkg::S_IDLE: begin
            if (req_fire) begin
               case (req_chan.opcode)
                  ssgs_pkg::OP_WRITE: begin
                     coef_we = 1'b1;
                     sol_we  = 1'b1;
                  end
                  ssgs_pkg::OP_SOLVE: begin
                     gw_in = (grid_w_ff == '0) ? GB'(1) :
                             ((grid_w_ff > GB'(ssgs_pkg::MAX_WIDTH)) ?
                              GB'(ssgs_pkg::MAX_WIDTH) : grid_w_ff);
                     gh_in = (grid_h_ff == '0) ? GB'(1) :
                             ((grid_h_ff > GB'(ssgs_pkg::MAX_HEIGHT)) ?
                              GB'(ssgs_pkg::MAX_HEIGHT) : grid_h_ff);
                     ivl_in       = (chk_ivl_ff == '0) ? 16'd1 : chk_ivl_ff;
                     last_iter_in = max_iter_ff;
                     it_in        = '0;
                     ivl_ph_in    = '0;
                     state_in     = ssgs_pkg::S_TOL;
                  end
                  ssgs_pkg::OP_READ: begin
                     ram_re   = 1'b1;
                     state_in = ssgs_pkg::S_RDOUT;
                  end
                  default: ;
               endcase
            end
         end
         ssgs_pkg::S_RDOUT: begin
            if (rsp_free) begin
               rsp_load      = 1'b1;
               rsp_cell_load = $signed(sol_rd);
               state_in      = ssgs_pkg::S_IDLE;
            end
         end
         ssgs_pkg::S_TOL: begin
            mul_a    = $signed({2'b00, tol_ff});
            mul_b    = $signed({2'b00, tol_ff});
            state_in = ssgs_pkg::S_BEGIN;
         end
         ssgs_pkg::S_BEGIN: begin
            tol2_in  = prod[ssgs_pkg::TOL2_BITS-1:0];
            resid_in = (max_iter_ff == '0);
            final_in = 1'b1;
            i_in     = '0;
            j_in     = '0;
            p_in     = 1'b0;
            sum_in   = '0;
            state_in = ssgs_pkg::S_CELL;
         end
         ssgs_pkg::S_CELL: begin
            ph_in = ssgs_pkg::PH_SELF;
            if (!resid_ff && rb_mode_ff && ((i_ff[0] ^ j_ff[0]) != p_ff))
               state_in = ssgs_pkg::S_NEXT;
            else
               state_in = ssgs_pkg::S_ADDR;
         end
         ssgs_pkg::S_ADDR: begin
            if (ph_ff == ssgs_pkg::PH_END) begin
               state_in = resid_ff ? ssgs_pkg::S_RPOST : ssgs_pkg::S_POST;
            end else if (!ex_cur) begin
               ph_in = ph_ff + 3'd1;
            end else begin
               ram_re   = 1'b1;
               raddr    = ph_addr;
               state_in = ssgs_pkg::S_DATA;
            end
         end
         ssgs_pkg::S_DATA: begin
            state_in = ssgs_pkg::S_ACC;
            case (ph_ff)
               ssgs_pkg::PH_SELF: begin
                  c_in   = $signed(center_rd);
                  rt_in  = $signed(right_rd);
                  up_in  = $signed(up_rd);
                  b_in   = $signed(rhs_rd);
                  x_in   = $signed(sol_rd);
                  acc_in = '0;
                  if (resid_ff) begin
                     mul_a = ssgs_pkg::OPND_BITS'($signed(center_rd));
                     mul_b = ssgs_pkg::OPND_BITS'($signed(sol_rd));
                  end else if (center_rd == '0) begin
                     // zero diagonal: cell keeps its value
                     state_in = ssgs_pkg::S_NEXT;
                  end else begin
                     ph_in    = ph_ff + 3'd1;
                     state_in = ssgs_pkg::S_ADDR;
                  end
               end
               ssgs_pkg::PH_RIGHT: begin
                  mul_a = ssgs_pkg::OPND_BITS'(rt_ff);
                  mul_b = ssgs_pkg::OPND_BITS'($signed(sol_rd));
               end
               ssgs_pkg::PH_LEFT: begin
                  mul_a = ssgs_pkg::OPND_BITS'($signed(right_rd));
                  mul_b = ssgs_pkg::OPND_BITS'($signed(sol_rd));
               end
               ssgs_pkg::PH_UP: begin
                  mul_a = ssgs_pkg::OPND_BITS'(up_ff);
                  mul_b = ssgs_pkg::OPND_BITS'($signed(sol_rd));
               end
               default: begin
                  mul_a = ssgs_pkg::OPND_BITS'($signed(up_rd));
                  mul_b = ssgs_pkg::OPND_BITS'($signed(sol_rd));
               end
            endcase
         end
         ssgs_pkg::S_ACC: begin
            acc_in   = acc_ff + ssgs_pkg::ACC_BITS'(prod >>> 16);
            ph_in    = ph_ff + 3'd1;
            state_in = ssgs_pkg::S_ADDR;
         end
         ssgs_pkg::S_POST: begin
            mul_a    = $signed({17'b0, relax_ff});
            mul_b    = ssgs_pkg::OPND_BITS'(d_val);
            state_in = ssgs_pkg::S_WD;
         end
         ssgs_pkg::S_WD: begin
            div_start = 1'b1;
            mul_a     = ssgs_pkg::ONE_Q14 - $signed({17'b0, relax_ff});
            mul_b     = ssgs_pkg::OPND_BITS'(x_ff);
            state_in  = ssgs_pkg::S_KEEP;
         end
         ssgs_pkg::S_KEEP: begin
            keep_in  = ssgs_pkg::KEEP_BITS'(prod >>> 14);
            state_in = ssgs_pkg::S_DIVW;
         end
         ssgs_pkg::S_DIVW: begin
            if (!div_busy) state_in = ssgs_pkg::S_WRITE;
         end
         ssgs_pkg::S_WRITE: begin
            sol_we    = 1'b1;
            waddr     = cell_addr;
            sol_wdata = ssgs_pkg::sat_value(ssgs_pkg::ACC_BITS'(keep_ff) +
                                            ssgs_pkg::ACC_BITS'(quotient));
            state_in  = ssgs_pkg::S_NEXT;
         end
         ssgs_pkg::S_RPOST: begin
            if (|mag[ssgs_pkg::DIFF_BITS-1:DW]) begin
               sum_in   = {ssgs_pkg::RESID_BITS{1'b1}};
               state_in = ssgs_pkg::S_NEXT;
            end else begin
               mul_a    = $signed({1'b0, mag[DW-1:0]});
               mul_b    = $signed({1'b0, mag[DW-1:0]});
               state_in = ssgs_pkg::S_RSQ;
            end
         end
         ssgs_pkg::S_RSQ: begin
            sum_in   = ssgs_pkg::sat_add(sum_ff, prod[ssgs_pkg::RESID_BITS-1:0]);
            state_in = ssgs_pkg::S_NEXT;
         end
         ssgs_pkg::S_NEXT: begin
            state_in = ssgs_pkg::S_CELL;
            if (ex_right) begin
               i_in = i_ff + CB'(1);
            end else begin
               i_in = '0;
               if (ex_up) begin
                  j_in = j_ff + RB'(1);
               end else begin
                  j_in = '0;
                  if (!resid_ff && rb_mode_ff && !p_ff) p_in = 1'b1;
                  else state_in = resid_ff ? ssgs_pkg::S_RDONE : ssgs_pkg::S_SWEND;
               end
            end
         end
         ssgs_pkg::S_SWEND: begin
            if (it_ff != '0 && ivl_ph_ff == '0) begin
               resid_in = 1'b1;
               final_in = 1'b0;
               i_in     = '0;
               j_in     = '0;
               p_in     = 1'b0;
               sum_in   = '0;
               state_in = ssgs_pkg::S_CELL;
            end else begin
               state_in = ssgs_pkg::S_ITNEXT;
            end
         end
         ssgs_pkg::S_RDONE: begin
            if (final_ff || below) begin
               last_resid_in = sum_ff;
               last_conv_in  = below;
               if (!final_ff) last_iter_in = it_ff + 16'd1;
               state_in = ssgs_pkg::S_OUT;
            end else begin
               state_in = ssgs_pkg::S_ITNEXT;
            end
         end
         ssgs_pkg::S_ITNEXT: begin
            i_in   = '0;
            j_in   = '0;
            p_in   = 1'b0;
            sum_in = '0;
            state_in = ssgs_pkg::S_CELL;
            if ({1'b0, it_ff} + 17'd1 == {1'b0, max_iter_ff}) begin
               resid_in = 1'b1;
               final_in = 1'b1;
            end else begin
               resid_in  = 1'b0;
               it_in     = it_ff + 16'd1;
               ivl_ph_in = ({1'b0, ivl_ph_ff} + 17'd1 == {1'b0, ivl_ff}) ? 16'd0 :
                           ivl_ph_ff + 16'd1;
            end
         end
         ssgs_pkg::S_OUT: begin
            if (rsp_free) begin
               rsp_load = 1'b1;
               state_in = ssgs_pkg::S_IDLE;
            end
         end
         default: state_in = ssgs_pkg::S_IDLE;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_cell_in  = rsp_cell_ff;
      rsp_conv_in  = rsp_conv_ff;
      rsp_iter_in  = rsp_iter_ff;
      rsp_resid_in = rsp_resid_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
         rsp_cell_in  = rsp_cell_load;
         rsp_conv_in  = last_conv_ff;
         rsp_iter_in  = last_iter_ff;
         rsp_resid_in = last_resid_ff;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ssgs_pkg::S_IDLE;
         rsp_valid_ff  <= 1'b0;
         max_iter_ff   <= 16'd100;
         chk_ivl_ff    <= 16'd1;
         tol_ff        <= ssgs_pkg::TOL_BITS'(66);
         relax_ff      <= 16'd16384;
         rb_mode_ff    <= 1'b0;
         grid_w_ff     <= GB'(32);
         grid_h_ff     <= GB'(32);
         last_iter_ff  <= '0;
         last_resid_ff <= '1;
         last_conv_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         rsp_valid_ff  <= rsp_valid_in;
         max_iter_ff   <= max_iter_in;
         chk_ivl_ff    <= chk_ivl_in;
         tol_ff        <= tol_in;
         relax_ff      <= relax_in;
         rb_mode_ff    <= rb_mode_in;
         grid_w_ff     <= grid_w_in;
         grid_h_ff     <= grid_h_in;
         last_iter_ff  <= last_iter_in;
         last_resid_ff <= last_resid_in;
         last_conv_ff  <= last_conv_in;
      end
      i_ff         <= i_in;
      j_ff         <= j_in;
      p_ff         <= p_in;
      ph_ff        <= ph_in;
      it_ff        <= it_in;
      ivl_ph_ff    <= ivl_ph_in;
      ivl_ff       <= ivl_in;
      resid_ff     <= resid_in;
      final_ff     <= final_in;
      gw_ff        <= gw_in;
      gh_ff        <= gh_in;
      tol2_ff      <= tol2_in;
      c_ff         <= c_in;
      rt_ff        <= rt_in;
      up_ff        <= up_in;
      b_ff         <= b_in;
      x_ff         <= x_in;
      acc_ff       <= acc_in;
      keep_ff      <= keep_in;
      sum_ff       <= sum_in;
      rsp_cell_ff  <= rsp_cell_in;
      rsp_conv_ff  <= rsp_conv_in;
      rsp_iter_ff  <= rsp_iter_in;
      rsp_resid_ff <= rsp_resid_in;
   end

   assign req_chan.ready           = (state_ff == ssgs_pkg::S_IDLE);
   assign rsp_chan.valid           = rsp_valid_ff;
   assign rsp_chan.cell_value      = rsp_cell_ff;
   assign rsp_chan.converged       = rsp_conv_ff;
   assign rsp_chan.iterations_used = rsp_iter_ff;
   assign rsp_chan.residual_sq     = rsp_resid_ff;

   ssgs_mul u_mul (
      .clock   (clock),
      .a       (mul_a),
      .b       (mul_b),
      .product (prod)
   );

   ssgs_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (c_ff),
      .busy     (div_busy),
      .quotient (quotient)
   );

   ssgs_ram #(.WIDTH(DW), .DEPTH(ssgs_pkg::CELLS)) u_center_ram (
      .clock (clock), .we (coef_we), .waddr (waddr), .wdata (req_chan.center_coeff),
      .re (ram_re), .raddr (raddr), .rdata (center_rd)
   );

   ssgs_ram #(.WIDTH(DW), .DEPTH(ssgs_pkg::CELLS)) u_right_ram (
      .clock (clock), .we (coef_we), .waddr (waddr), .wdata (req_chan.right_coeff),
      .re (ram_re), .raddr (raddr), .rdata (right_rd)
   );

   ssgs_ram #(.WIDTH(DW), .DEPTH(ssgs_pkg::CELLS)) u_up_ram (
      .clock (clock), .we (coef_we), .waddr (waddr), .wdata (req_chan.up_coeff),
      .re (ram_re), .raddr (raddr), .rdata (up_rd)
   );

   ssgs_ram #(.WIDTH(DW), .DEPTH(ssgs_pkg::CELLS)) u_rhs_ram (
      .clock (clock), .we (coef_we), .waddr (waddr), .wdata (req_chan.rhs_value),
      .re (ram_re), .raddr (raddr), .rdata (rhs_rd)
   );

   ssgs_ram #(.WIDTH(DW), .DEPTH(ssgs_pkg::CELLS)) u_sol_ram (
      .clock (clock), .we (sol_we), .waddr (waddr), .wdata (sol_wdata),
      .re (ram_re), .raddr (raddr), .rdata (sol_rd)
   );

   a_div_nonzero: assert property (@(posedge clock) disable iff (reset)
      div_start |-> c_ff != '0)
      else $error("divider started with zero diagonal");

   a_update_in_grid: assert property (@(posedge clock) disable iff (reset)
      (sol_we && state_ff != ssgs_pkg::S_IDLE) |-> (GB'(i_ff) < gw_ff && GB'(j_ff) < gh_ff))
      else $error("solution update outside grid in use");

   a_read_path: assert property (@(posedge clock) disable iff (reset)
      (req_fire && req_chan.opcode == ssgs_pkg::OP_READ) |=> state_ff == ssgs_pkg::S_RDOUT)
      else $error("read request did not reach output stage");

   a_sum_monotonic: assert property (@(posedge clock) disable iff (reset)
      state_ff == ssgs_pkg::S_RSQ |=> sum_ff >= $past(sum_ff))
      else $error("residual sum decreased");

endmodule
